[rtl/polyline_douglas_peucker_simplifier_assert.svh]
// assertion macros for the polyline simplifier
`ifndef POLYLINE_DOUGLAS_PEUCKER_SIMPLIFIER_ASSERT_SVH
`define POLYLINE_DOUGLAS_PEUCKER_SIMPLIFIER_ASSERT_SVH
`ifndef SYNTHESIS
`define PDP_ASSERT(lbl, prop) lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
  prop) else $error("pdp assertion failed");
`define PDP_NEVER(lbl, cond) lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
  !(cond)) else $error("pdp forbidden condition");
`else
`define PDP_ASSERT(lbl, prop)
`define PDP_NEVER(lbl, cond)
`endif
`endif

[rtl/pdp_pkg.sv]
// shared types and constants of the polyline simplifier
`default_nettype none
package pdp_pkg;
  localparam int MaxPoints = 64;
  localparam int IdxW      = $clog2(MaxPoints);
  localparam int CntW      = $clog2(MaxPoints + 1);
  localparam int CoordW    = 24;
  localparam int IdW       = 16;
  localparam int TolW      = 24;
  localparam logic [TolW-1:0] TolReset = 24'd256;
  localparam int DiffW     = CoordW + 1;
  localparam int HalfW     = 25;
  localparam int OpW       = HalfW + 1;
  localparam int ProdW     = 2 * OpW;
  localparam int SqW       = 2 * HalfW;
  localparam int DotW      = SqW + 1;
  localparam int WideW     = 2 * SqW;
  localparam int AccW      = WideW + 1;
  localparam int StkW      = 2 * IdxW;
  localparam int StepW     = 4;

  typedef enum logic [1:0] {MAC_NOP, MAC_LD, MAC_ADD, MAC_SUB} mac_op_e;
  typedef enum logic [3:0] {
    OPS_PXS, OPS_PYS, OPS_PXE, OPS_PYE, OPS_DX, OPS_DY, OPS_TOL,
    OPS_W0, OPS_W1, OPS_M0, OPS_M1
  } opnd_e;
  typedef enum logic [1:0] {SH_0, SH_1H, SH_2H} shift_e;
  typedef enum logic [3:0] {
    DST_NONE, DST_DPS, DST_DOT, DST_CRS, DST_DPE, DST_LEN, DST_T2, DST_LIM, DST_RES
  } dst_e;

  typedef struct packed {
    mac_op_e op;
    opnd_e   a;
    opnd_e   b;
    shift_e  sh;
    dst_e    dst;
  } mac_t;

  typedef struct packed {
    logic            ld_we;
    logic [IdxW-1:0] ld_addr;
    logic [IdxW-1:0] rd_addr;
    logic            lat_s;
    logic            lat_e;
    logic            lat_p;
    mac_t            mac;
    logic            sel_lim;
    logic            sel_dist;
    logic            best_clr;
    logic            best_upd;
    logic            keep_set;
    logic            keep_clr;
    logic [IdxW-1:0] keep_idx;
    logic            stk_we;
    logic [IdxW-1:0] stk_waddr;
    logic [StkW-1:0] stk_wdata;
    logic [IdxW-1:0] stk_raddr;
  } cmd_t;

  typedef struct packed {
    logic [StkW-1:0] stk_rdata;
    logic            gt;
    logic            over;
  } sts_t;
endpackage
`default_nettype wire

[rtl/polyline_douglas_peucker_simplifier.sv]
// top level of the Douglas-Peucker polyline simplifier
`default_nettype none
// Loads up to 64 path points (node id, signed Q16.8 x and y), one per input
// beat; points beyond 64 are dropped and flag overflow. The beat with tlast
// stores its point and starts the simplification: both endpoints are kept and
// segments are taken from an explicit stack. For each segment the farthest
// interior point (exact squared distance, ties to the lower index) is kept
// and splits the segment when it lies beyond the tolerance. Then every loaded
// point is sent in path order, one output beat each, with its kept flag.
// Input is taken only while loading. The work per path is set by the single
// shared 26x26 multiply-accumulate unit, which serves each segment and each
// interior point visited (about n log n to n^2 visits for n points); each
// output beat waits for the registered id memory read before it is offered.
// Tolerance is written through tol_we_i / tol_wdata_i; the user must write it
// only while idle, as the block itself does not enforce this.
module polyline_douglas_peucker_simplifier (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,   // node_id[15:0], coord_x[39:16], coord_y[63:40]
  input  logic        s_axis_tlast_i,   // last point of the path
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // out_node_id[15:0], kept[16], overflow[17], zero
  output logic        m_axis_tlast_o,   // last point of the path
  input  logic        tol_we_i,
  input  logic [23:0] tol_wdata_i       // tolerance, unsigned Q16.8
);
  import pdp_pkg::*;

  cmd_t           cmd;
  sts_t           sts;
  logic [IdW-1:0] out_id;
  logic           out_kept;
  logic           ovf;

  // sequencing of load, stack walk, point scan and emission
  pdp_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_last_i  (s_axis_tlast_i),
    .s_ready_o (s_axis_tready_o),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .m_last_o  (m_axis_tlast_o),
    .m_ovf_o   (ovf),
    .cmd_o     (cmd),
    .sts_i     (sts)
  );

  // memories and distance arithmetic
  pdp_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_id_i     (s_axis_tdata_i[15:0]),
    .in_x_i      (s_axis_tdata_i[39:16]),
    .in_y_i      (s_axis_tdata_i[63:40]),
    .tol_we_i    (tol_we_i),
    .tol_wdata_i (tol_wdata_i),
    .out_id_o    (out_id),
    .out_kept_o  (out_kept)
  );

  // output beat packing
  assign m_axis_tdata_o = {6'b0, ovf, out_kept, out_id};
endmodule
`default_nettype wire

[rtl/pdp_dpath.sv]
// datapath: point and stack memories, shared multiply-accumulate, compares
`default_nettype none
module pdp_dpath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pdp_pkg::cmd_t                 cmd_i,
  output pdp_pkg::sts_t                 sts_o,
  input  logic [pdp_pkg::IdW-1:0]       in_id_i,
  input  logic [pdp_pkg::CoordW-1:0]    in_x_i,
  input  logic [pdp_pkg::CoordW-1:0]    in_y_i,
  input  logic                          tol_we_i,
  input  logic [pdp_pkg::TolW-1:0]      tol_wdata_i,
  output logic [pdp_pkg::IdW-1:0]       out_id_o,
  output logic                          out_kept_o
);
  import pdp_pkg::*;

  logic [2*CoordW-1:0] xy_mem [MaxPoints];
  logic [IdW-1:0]      id_mem [MaxPoints];
  logic [StkW-1:0]     stk_mem [MaxPoints];
  logic [2*CoordW-1:0] xy_rd_q;
  logic [IdW-1:0]      id_rd_q;
  logic [StkW-1:0]     stk_rd_q;

  logic [TolW-1:0]         tol_q;
  logic [MaxPoints-1:0]    keep_q;
  logic signed [CoordW-1:0] rx, ry, sx_q, sy_q, ex_q, ey_q;
  logic signed [DiffW-1:0] dx_q, dy_q, pxs_q, pys_q, pxe_q, pye_q;
  logic signed [ProdW-1:0] prod_q;
  mac_op_e                 op_q;
  shift_e                  sh_q;
  dst_e                    dst_q;
  logic signed [AccW-1:0]  acc_q, acc_d, term;
  logic signed [OpW-1:0]   a_op, b_op;
  logic [SqW-1:0]          dps_q, dpe_q, len_q, w_q, m_q, crs_mag;
  logic signed [DotW-1:0]  dot_q, crs_q, crs_abs;
  logic [2*TolW-1:0]       t2_q;
  logic [WideW-1:0]        lim_q, res_q, best_d_q;

  // memories
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_we) begin
      xy_mem[cmd_i.ld_addr] <= {in_y_i, in_x_i};
      id_mem[cmd_i.ld_addr] <= in_id_i;
    end
    xy_rd_q <= xy_mem[cmd_i.rd_addr];
    id_rd_q <= id_mem[cmd_i.rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.stk_we) begin
      stk_mem[cmd_i.stk_waddr] <= cmd_i.stk_wdata;
    end
    stk_rd_q <= stk_mem[cmd_i.stk_raddr];
  end

  assign rx = xy_rd_q[CoordW-1:0];
  assign ry = xy_rd_q[2*CoordW-1:CoordW];

  // tolerance register and keep flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q  <= TolReset;
      keep_q <= '0;
    end else begin
      if (tol_we_i) tol_q <= tol_wdata_i;
      if (cmd_i.keep_clr) keep_q <= '0;
      else if (cmd_i.keep_set) keep_q[cmd_i.keep_idx] <= 1'b1;
    end
  end

  // coordinate latches and differences
  always_ff @(posedge clk_i) begin
    if (cmd_i.lat_s) begin
      sx_q <= rx;
      sy_q <= ry;
    end
    if (cmd_i.lat_e) begin
      ex_q <= rx;
      ey_q <= ry;
      dx_q <= DiffW'(rx) - DiffW'(sx_q);
      dy_q <= DiffW'(ry) - DiffW'(sy_q);
    end
    if (cmd_i.lat_p) begin
      pxs_q <= DiffW'(rx) - DiffW'(sx_q);
      pys_q <= DiffW'(ry) - DiffW'(sy_q);
      pxe_q <= DiffW'(rx) - DiffW'(ex_q);
      pye_q <= DiffW'(ry) - DiffW'(ey_q);
    end
  end

  function automatic logic signed [OpW-1:0] pick(
    opnd_e sel, logic signed [DiffW-1:0] pxs, logic signed [DiffW-1:0] pys,
    logic signed [DiffW-1:0] pxe, logic signed [DiffW-1:0] pye,
    logic signed [DiffW-1:0] dx, logic signed [DiffW-1:0] dy,
    logic [TolW-1:0] tol, logic [SqW-1:0] w, logic [SqW-1:0] m);
    logic signed [OpW-1:0] r;
    case (sel)
      OPS_PXS: r = OpW'(pxs);
      OPS_PYS: r = OpW'(pys);
      OPS_PXE: r = OpW'(pxe);
      OPS_PYE: r = OpW'(pye);
      OPS_DX:  r = OpW'(dx);
      OPS_DY:  r = OpW'(dy);
      OPS_TOL: r = $signed({{(OpW-TolW){1'b0}}, tol});
      OPS_W0:  r = $signed({1'b0, w[HalfW-1:0]});
      OPS_W1:  r = $signed({1'b0, w[SqW-1:HalfW]});
      OPS_M0:  r = $signed({1'b0, m[HalfW-1:0]});
      OPS_M1:  r = $signed({1'b0, m[SqW-1:HalfW]});
      default: r = '0;
    endcase
    return r;
  endfunction

  assign a_op = pick(cmd_i.mac.a, pxs_q, pys_q, pxe_q, pye_q, dx_q, dy_q, tol_q, w_q, m_q);
  assign b_op = pick(cmd_i.mac.b, pxs_q, pys_q, pxe_q, pye_q, dx_q, dy_q, tol_q, w_q, m_q);

  // multiplier stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q  <= MAC_NOP;
      sh_q  <= SH_0;
      dst_q <= DST_NONE;
    end else begin
      op_q  <= cmd_i.mac.op;
      sh_q  <= cmd_i.mac.sh;
      dst_q <= cmd_i.mac.dst;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= a_op * b_op;
  end

  // accumulate stage
  always_comb begin
    case (sh_q)
      SH_1H:   term = AccW'(prod_q) <<< HalfW;
      SH_2H:   term = AccW'(prod_q) <<< (2 * HalfW);
      default: term = AccW'(prod_q);
    endcase
    case (op_q)
      MAC_LD:  acc_d = term;
      MAC_ADD: acc_d = acc_q + term;
      MAC_SUB: acc_d = acc_q - term;
      default: acc_d = acc_q;
    endcase
  end

  assign crs_abs = crs_q[DotW-1] ? -crs_q : crs_q;
  assign crs_mag = crs_abs[SqW-1:0];

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    case (dst_q)
      DST_DPS: dps_q <= acc_d[SqW-1:0];
      DST_DOT: dot_q <= acc_d[DotW-1:0];
      DST_CRS: crs_q <= acc_d[DotW-1:0];
      DST_DPE: dpe_q <= acc_d[SqW-1:0];
      DST_LEN: len_q <= acc_d[SqW-1:0];
      DST_T2:  t2_q  <= acc_d[2*TolW-1:0];
      DST_LIM: lim_q <= acc_d[WideW-1:0];
      DST_RES: res_q <= acc_d[WideW-1:0];
      default: ;
    endcase
    // operand pair for the wide product
    if (cmd_i.sel_lim) begin
      w_q <= SqW'(t2_q);
      m_q <= (len_q == '0) ? SqW'(1) : len_q;
    end else if (cmd_i.sel_dist) begin
      if (len_q == '0) begin
        w_q <= dps_q;
        m_q <= SqW'(1);
      end else if (dot_q <= 0) begin
        w_q <= dps_q;
        m_q <= len_q;
      end else if (dot_q >= $signed({1'b0, len_q})) begin
        w_q <= dpe_q;
        m_q <= len_q;
      end else begin
        w_q <= crs_mag;
        m_q <= crs_mag;
      end
    end
    if (cmd_i.best_clr) best_d_q <= '0;
    else if (cmd_i.best_upd && (res_q > best_d_q)) best_d_q <= res_q;
  end

  assign sts_o.stk_rdata = stk_rd_q;
  assign sts_o.gt        = res_q > best_d_q;
  assign sts_o.over      = best_d_q > lim_q;

  assign out_id_o   = id_rd_q;
  assign out_kept_o = keep_q[cmd_i.keep_idx];
endmodule
`default_nettype wire

[rtl/pdp_ctrl.sv]
// controller: load, segment stack walk, point scan sequencing and emission
`default_nettype none
`include "polyline_douglas_peucker_simplifier_assert.svh"
module pdp_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_valid_i,
  input  logic          s_last_i,
  output logic          s_ready_o,
  output logic          m_valid_o,
  input  logic          m_ready_i,
  output logic          m_last_o,
  output logic          m_ovf_o,
  output pdp_pkg::cmd_t cmd_o,
  input  pdp_pkg::sts_t sts_i
);
  import pdp_pkg::*;

  typedef enum logic [15:0] {
    ST_LOAD  = 16'h0001,
    ST_KEEP0 = 16'h0002,
    ST_KEEPN = 16'h0004,
    ST_POP   = 16'h0008,
    ST_STK   = 16'h0010,
    ST_RDS   = 16'h0020,
    ST_RDE   = 16'h0040,
    ST_SMAC  = 16'h0080,
    ST_PRD   = 16'h0100,
    ST_PLAT  = 16'h0200,
    ST_PMAC  = 16'h0400,
    ST_SEND  = 16'h0800,
    ST_PUSH  = 16'h1000,
    ST_EMRD  = 16'h2000,
    ST_EMOUT = 16'h4000,
    ST_SPARE = 16'h8000
  } state_e;

  state_e            state_q, state_d;
  logic [CntW-1:0]   cnt_q, cnt_d, depth_q, depth_d;
  logic              ovf_q, ovf_d;
  logic [IdxW-1:0]   idx_q, idx_d, seg_s_q, seg_s_d, seg_e_q, seg_e_d, best_q, best_d;
  logic [StepW-1:0]  step_q, step_d;
  logic [IdxW-1:0]   last_idx;
  logic              depth_ok;

  assign last_idx = IdxW'(cnt_q - CntW'(1));
  assign depth_ok = depth_q < CntW'(MaxPoints);

  function automatic mac_t mk(mac_op_e op, opnd_e a, opnd_e b, shift_e sh, dst_e dst);
    mac_t m;
    m.op = op; m.a = a; m.b = b; m.sh = sh; m.dst = dst;
    return m;
  endfunction

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    depth_d = depth_q;
    ovf_d   = ovf_q;
    idx_d   = idx_q;
    seg_s_d = seg_s_q;
    seg_e_d = seg_e_q;
    best_d  = best_q;
    step_d  = step_q;
    cmd_o   = '0;
    cmd_o.mac = mk(MAC_NOP, OPS_PXS, OPS_PXS, SH_0, DST_NONE);
    cmd_o.rd_addr = idx_q;
    cmd_o.keep_idx = idx_q;
    s_ready_o = 1'b0;
    m_valid_o = 1'b0;
    m_last_o  = (idx_q == last_idx);
    unique case (state_q)
      ST_LOAD: begin
        s_ready_o = 1'b1;
        cmd_o.ld_addr = cnt_q[IdxW-1:0];
        if (s_valid_i) begin
          if (cnt_q < CntW'(MaxPoints)) begin
            cmd_o.ld_we = 1'b1;
            cnt_d = cnt_q + CntW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (s_last_i) state_d = ST_KEEP0;
        end
      end
      ST_KEEP0: begin
        cmd_o.keep_set = 1'b1;
        cmd_o.keep_idx = '0;
        state_d = ST_KEEPN;
      end
      ST_KEEPN: begin
        cmd_o.keep_set = 1'b1;
        cmd_o.keep_idx = last_idx;
        cmd_o.stk_waddr = depth_q[IdxW-1:0];
        cmd_o.stk_wdata = {{IdxW{1'b0}}, last_idx};
        if (cnt_q > CntW'(2) && depth_ok) begin
          cmd_o.stk_we = 1'b1;
          depth_d = depth_q + CntW'(1);
        end
        state_d = ST_POP;
      end
      ST_POP: begin
        cmd_o.stk_raddr = IdxW'(depth_q - CntW'(1));
        if (depth_q == '0) begin
          idx_d = '0;
          state_d = ST_EMRD;
        end else begin
          depth_d = depth_q - CntW'(1);
          state_d = ST_STK;
        end
      end
      ST_STK: begin
        seg_s_d = sts_i.stk_rdata[StkW-1:IdxW];
        seg_e_d = sts_i.stk_rdata[IdxW-1:0];
        state_d = ST_RDS;
      end
      ST_RDS: begin
        cmd_o.rd_addr = seg_s_q;
        state_d = ST_RDE;
      end
      ST_RDE: begin
        cmd_o.rd_addr = seg_e_q;
        cmd_o.lat_s = 1'b1;
        step_d = '0;
        state_d = ST_SMAC;
      end
      ST_SMAC: begin
        step_d = step_q + StepW'(1);
        case (step_q)
          4'd0: begin
            cmd_o.lat_e = 1'b1;
            cmd_o.mac = mk(MAC_LD, OPS_TOL, OPS_TOL, SH_0, DST_T2);
          end
          4'd1: cmd_o.mac = mk(MAC_LD, OPS_DX, OPS_DX, SH_0, DST_NONE);
          4'd2: cmd_o.mac = mk(MAC_ADD, OPS_DY, OPS_DY, SH_0, DST_LEN);
          4'd4: cmd_o.sel_lim = 1'b1;
          4'd5: cmd_o.mac = mk(MAC_LD, OPS_W0, OPS_M0, SH_0, DST_NONE);
          4'd6: cmd_o.mac = mk(MAC_ADD, OPS_W1, OPS_M0, SH_1H, DST_NONE);
          4'd7: cmd_o.mac = mk(MAC_ADD, OPS_W0, OPS_M1, SH_1H, DST_NONE);
          4'd8: cmd_o.mac = mk(MAC_ADD, OPS_W1, OPS_M1, SH_2H, DST_LIM);
          4'd9: begin
            cmd_o.best_clr = 1'b1;
            idx_d  = seg_s_q + IdxW'(1);
            best_d = seg_s_q;
            state_d = ST_PRD;
          end
          default: ;
        endcase
      end
      ST_PRD: begin
        if (idx_q >= seg_e_q) begin
          state_d = ST_SEND;
        end else begin
          state_d = ST_PLAT;
        end
      end
      ST_PLAT: begin
        cmd_o.lat_p = 1'b1;
        step_d = '0;
        state_d = ST_PMAC;
      end
      ST_PMAC: begin
        step_d = step_q + StepW'(1);
        case (step_q)
          4'd0:  cmd_o.mac = mk(MAC_LD, OPS_PXS, OPS_PXS, SH_0, DST_NONE);
          4'd1:  cmd_o.mac = mk(MAC_ADD, OPS_PYS, OPS_PYS, SH_0, DST_DPS);
          4'd2:  cmd_o.mac = mk(MAC_LD, OPS_PXS, OPS_DX, SH_0, DST_NONE);
          4'd3:  cmd_o.mac = mk(MAC_ADD, OPS_PYS, OPS_DY, SH_0, DST_DOT);
          4'd4:  cmd_o.mac = mk(MAC_LD, OPS_PXS, OPS_DY, SH_0, DST_NONE);
          4'd5:  cmd_o.mac = mk(MAC_SUB, OPS_PYS, OPS_DX, SH_0, DST_CRS);
          4'd6:  cmd_o.mac = mk(MAC_LD, OPS_PXE, OPS_PXE, SH_0, DST_NONE);
          4'd7:  cmd_o.mac = mk(MAC_ADD, OPS_PYE, OPS_PYE, SH_0, DST_DPE);
          4'd9:  cmd_o.sel_dist = 1'b1;
          4'd10: cmd_o.mac = mk(MAC_LD, OPS_W0, OPS_M0, SH_0, DST_NONE);
          4'd11: cmd_o.mac = mk(MAC_ADD, OPS_W1, OPS_M0, SH_1H, DST_NONE);
          4'd12: cmd_o.mac = mk(MAC_ADD, OPS_W0, OPS_M1, SH_1H, DST_NONE);
          4'd13: cmd_o.mac = mk(MAC_ADD, OPS_W1, OPS_M1, SH_2H, DST_RES);
          4'd15: begin
            cmd_o.best_upd = 1'b1;
            if (sts_i.gt) best_d = idx_q;
            idx_d = idx_q + IdxW'(1);
            state_d = ST_PRD;
          end
          default: ;
        endcase
      end
      ST_SEND: begin
        cmd_o.keep_idx  = best_q;
        cmd_o.stk_waddr = depth_q[IdxW-1:0];
        cmd_o.stk_wdata = {best_q, seg_e_q};
        if (sts_i.over) begin
          cmd_o.keep_set = 1'b1;
          if ({1'b0, seg_e_q} > ({1'b0, best_q} + (IdxW+1)'(1)) && depth_ok) begin
            cmd_o.stk_we = 1'b1;
            depth_d = depth_q + CntW'(1);
          end
          state_d = ST_PUSH;
        end else begin
          state_d = ST_POP;
        end
      end
      ST_PUSH: begin
        cmd_o.stk_waddr = depth_q[IdxW-1:0];
        cmd_o.stk_wdata = {seg_s_q, best_q};
        if ({1'b0, best_q} > ({1'b0, seg_s_q} + (IdxW+1)'(1)) && depth_ok) begin
          cmd_o.stk_we = 1'b1;
          depth_d = depth_q + CntW'(1);
        end
        state_d = ST_POP;
      end
      ST_EMRD: begin
        state_d = ST_EMOUT;
      end
      ST_EMOUT: begin
        m_valid_o = 1'b1;
        if (m_ready_i) begin
          if (m_last_o) begin
            cmd_o.keep_clr = 1'b1;
            cnt_d   = '0;
            ovf_d   = 1'b0;
            state_d = ST_LOAD;
          end else begin
            idx_d   = idx_q + IdxW'(1);
            state_d = ST_EMRD;
          end
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  assign m_ovf_o = ovf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      cnt_q   <= '0;
      depth_q <= '0;
      ovf_q   <= 1'b0;
      idx_q   <= '0;
      seg_s_q <= '0;
      seg_e_q <= '0;
      best_q  <= '0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      depth_q <= depth_d;
      ovf_q   <= ovf_d;
      idx_q   <= idx_d;
      seg_s_q <= seg_s_d;
      seg_e_q <= seg_e_d;
      best_q  <= best_d;
      step_q  <= step_d;
    end
  end

  `PDP_ASSERT(a_depth_cap, depth_q <= CntW'(MaxPoints))
  `PDP_ASSERT(a_emit_nonempty, m_valid_o |-> cnt_q != '0)
  `PDP_ASSERT(a_scan_inside, state_q == ST_PMAC |-> idx_q < seg_e_q)
  `PDP_ASSERT(a_clear_after_path, (m_valid_o && m_ready_i && m_last_o) |=> (cnt_q == '0 && !ovf_q))
  `PDP_NEVER(a_sides_exclusive, s_ready_o && m_valid_o)
endmodule
`default_nettype wire

[sim/tb_polyline_douglas_peucker_simplifier.sv]
// testbench for the Douglas-Peucker polyline simplifier
`timescale 1ns / 1ps

module tb_polyline_douglas_peucker_simplifier;
  import pdp_pkg::*;

  localparam int  CycleLimit = 3000000;
  localparam int  DrainWait  = 40;   // clearing after the last beat of a path

  typedef struct packed {
    logic [15:0] node_id;
    logic        kept;
    logic        overflow;
    logic        last;
  } point_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [63:0] s_axis_tdata_i = '0;   // node_id[15:0], coord_x[39:16], coord_y[63:40]
  logic        s_axis_tlast_i = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [23:0] m_axis_tdata_o;        // out_node_id[15:0], kept[16], overflow[17], zero
  logic        m_axis_tlast_o;
  logic        tol_we_i = 1'b0;
  logic [23:0] tol_wdata_i = '0;

  polyline_douglas_peucker_simplifier u_top (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tdata_i, .s_axis_tlast_i,
    .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o, .m_axis_tlast_o,
    .tol_we_i, .tol_wdata_i
  );

  always #4 clk_i = ~clk_i;

  // predictor copy of the block state
  longint      pt_x [MaxPoints];
  longint      pt_y [MaxPoints];
  logic [15:0] pt_id [MaxPoints];
  bit          pt_keep [MaxPoints];
  int          pt_count = 0;
  bit          path_ovf = 1'b0;
  logic [23:0] tol_model = TolReset;

  point_result_t pending_points[$];

  int  mismatches = 0;
  int  beats_sent = 0;
  int  results_seen = 0;
  int  paths_sent = 0;
  int  tol_writes = 0;
  bit  quiet = 1'b0;      // no idling in the final stretch
  longint cycles = 0;

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic logic [127:0] wide_mul(longint a, longint b);
    logic [127:0] wa, wb;
    wa = a;
    wb = b;
    return wa * wb;
  endfunction

  function automatic longint sq_between(int a, int b);
    longint ex, ey;
    ex = mag(pt_x[a] - pt_x[b]);
    ey = mag(pt_y[a] - pt_y[b]);
    return ex * ex + ey * ey;
  endfunction

  // squared distance of p to s..e, scaled by the squared segment length
  function automatic logic [127:0] seg_dist(int p, int s, int e);
    longint dx, dy, px, py, len, dot, c;
    dx = pt_x[e] - pt_x[s];
    dy = pt_y[e] - pt_y[s];
    px = pt_x[p] - pt_x[s];
    py = pt_y[p] - pt_y[s];
    len = dx * dx + dy * dy;
    if (len == 0) return wide_mul(sq_between(p, s), 1);
    dot = px * dx + py * dy;
    if (dot <= 0) return wide_mul(sq_between(p, s), len);
    if (dot >= len) return wide_mul(sq_between(p, e), len);
    c = mag(px * dy - py * dx);
    return wide_mul(c, c);
  endfunction

  // mark the surviving points with an explicit segment stack
  task automatic mark_kept_points();
    int stk_s [MaxPoints];
    int stk_e [MaxPoints];
    int depth, s, e, best;
    longint dx, dy, len;
    logic [127:0] limit, best_d, d;
    depth = 0;
    if (pt_count == 0) return;
    pt_keep[0] = 1'b1;
    pt_keep[pt_count-1] = 1'b1;
    if (pt_count > 2) begin
      stk_s[0] = 0;
      stk_e[0] = pt_count - 1;
      depth = 1;
    end
    while (depth > 0) begin
      depth--;
      s = stk_s[depth];
      e = stk_e[depth];
      dx = pt_x[e] - pt_x[s];
      dy = pt_y[e] - pt_y[s];
      len = dx * dx + dy * dy;
      limit = wide_mul(longint'(tol_model) * longint'(tol_model), len == 0 ? 1 : len);
      best = s;
      best_d = '0;
      for (int i = s + 1; i < e; i++) begin
        d = seg_dist(i, s, e);
        if (d > best_d) begin
          best_d = d;
          best = i;
        end
      end
      if (best_d > limit) begin
        pt_keep[best] = 1'b1;
        if (e > best + 1 && depth < MaxPoints) begin
          stk_s[depth] = best; stk_e[depth] = e; depth++;
        end
        if (best > s + 1 && depth < MaxPoints) begin
          stk_s[depth] = s; stk_e[depth] = best; depth++;
        end
      end
    end
  endtask

  task automatic model_accept(logic [15:0] id, logic [23:0] x, logic [23:0] y, bit last);
    point_result_t r;
    if (pt_count < MaxPoints) begin
      pt_id[pt_count] = id;
      pt_x[pt_count] = longint'(signed'(x));
      pt_y[pt_count] = longint'(signed'(y));
      pt_keep[pt_count] = 1'b0;
      pt_count++;
    end else begin
      path_ovf = 1'b1;
    end
    if (!last) return;
    mark_kept_points();
    for (int i = 0; i < pt_count; i++) begin
      r.node_id = pt_id[i];
      r.kept = pt_keep[i];
      r.overflow = path_ovf;
      r.last = (i == pt_count - 1);
      pending_points = {pending_points, r};
    end
    for (int i = 0; i < MaxPoints; i++) pt_keep[i] = 1'b0;
    pt_count = 0;
    path_ovf = 1'b0;
    paths_sent++;
  endtask

  // one input beat; tvalid stays high for a following beat
  task automatic send_point(logic [15:0] id, logic [23:0] x, logic [23:0] y, bit last);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {y, x, id};
    s_axis_tlast_i  <= last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    model_accept(id, x, y, last);
    beats_sent++;
  endtask

  // wait until every expected point is out and the block has cleared
  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    wait (pending_points.size() == 0);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic set_tolerance(logic [23:0] v);
    drain();
    tol_we_i <= 1'b1;
    tol_wdata_i <= v;
    @(posedge clk_i);
    tol_we_i <= 1'b0;
    tol_model = v;
    tol_writes++;
  endtask

  // points near a straight line with noise, so keep decisions vary
  task automatic send_noisy_path(int n, int noise);
    int x0, y0, sx, sy;
    x0 = $urandom_range(0, 2000000) - 1000000;
    y0 = $urandom_range(0, 2000000) - 1000000;
    sx = $urandom_range(0, 20000) - 10000;
    sy = $urandom_range(0, 20000) - 10000;
    for (int i = 0; i < n; i++)
      send_point(16'($urandom), 24'(x0 + i * sx + $urandom_range(0, 2 * noise) - noise),
                 24'(y0 + i * sy + $urandom_range(0, 2 * noise) - noise), i == n - 1);
  endtask

  task automatic test_short_paths();
    send_point(16'h0000, 24'h800000, 24'h7fffff, 1'b1);   // single point
    send_point(16'hffff, 24'h7fffff, 24'h800000, 1'b0);   // two points
    send_point(16'h1234, 24'h000000, 24'h000000, 1'b1);
    drain();
  endtask

  task automatic test_special_shapes();
    // equal distances on both sides: the lower index wins
    send_point(16'd1, 24'd0, 24'd0, 1'b0);
    send_point(16'd2, 24'd1000, 24'd700, 1'b0);
    send_point(16'd3, 24'd2000, -24'sd700, 1'b0);
    send_point(16'd4, 24'd3000, 24'd0, 1'b1);
    // closed loop: start and end coincide
    send_point(16'd10, 24'd5000, 24'd5000, 1'b0);
    send_point(16'd11, 24'd5100, 24'd5000, 1'b0);
    send_point(16'd12, 24'd5000, 24'd5600, 1'b0);
    send_point(16'd13, 24'd5000, 24'd5000, 1'b1);
    // points beyond either end of the segment, and far corners
    send_point(16'd20, 24'd0, 24'd0, 1'b0);
    send_point(16'd21, -24'sd900, 24'd10, 1'b0);
    send_point(16'd22, 24'd2900, 24'd10, 1'b0);
    send_point(16'd23, 24'h7fffff, 24'h800000, 1'b0);
    send_point(16'd24, 24'h800000, 24'h7fffff, 1'b0);
    send_point(16'd25, 24'd2000, 24'd0, 1'b1);
    drain();
  endtask

  task automatic test_full_store();
    // everything survives at zero tolerance on a zig-zag
    set_tolerance(24'd0);
    for (int i = 0; i < MaxPoints; i++)
      send_point(16'(i), 24'(i * 300), 24'((i % 2) * 500), i == MaxPoints - 1);
    drain();
    // two extra beats are dropped, the last one still ends the path
    set_tolerance(24'hffffff);
    for (int i = 0; i < MaxPoints + 2; i++)
      send_point(16'($urandom), 24'($urandom), 24'($urandom), i == MaxPoints + 1);
    drain();
  endtask

  task automatic test_tolerance_sweep();
    logic [23:0] tols [4] = '{24'd0, 24'd256, 24'd4096, 24'hffffff};
    foreach (tols[k]) begin
      set_tolerance(tols[k]);
      repeat (3) send_noisy_path($urandom_range(3, 8), 6000);
    end
  endtask

  task automatic test_random_paths();
    int n;
    while (beats_sent < 420) begin
      if ($urandom_range(0, 5) == 0)
        set_tolerance(24'($urandom_range(0, 24'hffffff) >> $urandom_range(0, 20)));
      if (beats_sent > 360) quiet = 1'b1;
      n = ($urandom_range(0, 15) == 0) ? $urandom_range(13, 24) : $urandom_range(1, 10);
      if ($urandom_range(0, 3) == 0) begin
        for (int i = 0; i < n; i++)
          send_point(16'($urandom), 24'($urandom), 24'($urandom), i == n - 1);
      end else begin
        send_noisy_path(n, 1 << $urandom_range(4, 14));
      end
    end
    drain();
  endtask

  // sink side stalls in bursts
  int stall_left = 0;
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready_i <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 7);
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  // compare each output beat with the oldest expected point
  always @(posedge clk_i) begin
    point_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      results_seen++;
      if (pending_points.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output beat: data %h", m_axis_tdata_o);
      end else begin
        want = pending_points.pop_front();
        if (m_axis_tdata_o[15:0] !== want.node_id || m_axis_tdata_o[16] !== want.kept ||
            m_axis_tdata_o[17] !== want.overflow || m_axis_tlast_o !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"point mismatch: want id %h kept %b ovf %b last %b, ",
                      "got id %h kept %b ovf %b last %b"},
                     want.node_id, want.kept, want.overflow, want.last, m_axis_tdata_o[15:0],
                     m_axis_tdata_o[16], m_axis_tdata_o[17], m_axis_tlast_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_short_paths();
    test_special_shapes();
    test_full_store();
    test_tolerance_sweep();
    test_random_paths();
    repeat (DrainWait) @(posedge clk_i);
    mismatches += pending_points.size();
    $display("sent %0d beats in %0d paths, checked %0d output beats", beats_sent, paths_sent,
             results_seen);
    $display("tolerance written %0d times, including zero and full scale", tol_writes);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/pdp_pkg.sv
rtl/pdp_dpath.sv
rtl/pdp_ctrl.sv
rtl/polyline_douglas_peucker_simplifier.sv
sim/tb_polyline_douglas_peucker_simplifier.sv
